// File: src/stmsn_pkg.sv
// shared types and constants for the short-time mean and scale normalizer
`default_nettype none

package stmsn_pkg;

	// fixed field widths
	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 15;
	localparam int NORM_BITS   = FRAC_BITS + 1;
	localparam int QUOT_BITS   = FRAC_BITS + 1;
	localparam int CFG_BITS    = 7;

	// window length register
	localparam logic [CFG_BITS-1:0] LEN_RESET = 7'd8;
	localparam logic [CFG_BITS-1:0] LEN_MIN   = 7'd2;
	localparam int HALF_DIV = 2;

	// sample and result limits
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [NORM_BITS-1:0] NORM_MAX = {1'b0, {(NORM_BITS-1){1'b1}}};

	// input item
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          stream_last;
	} in_item_t;

	// result item
	typedef struct packed {
		logic signed [NORM_BITS-1:0] norm_value;
		logic                        stream_end;
	} out_item_t;

endpackage

`default_nettype wire

// File: src/stmsn_cell.sv
// one window cell: holds one sample and folds it into the passing statistics
`default_nettype none

module stmsn_cell import stmsn_pkg::*; #(
	parameter int INDEX = 0,
	parameter int CW    = 7,
	parameter int SW    = 23
) (
	input  logic                          clk,
	input  logic                          shift_en,
	input  logic [CW-1:0]                 hi,
	input  logic [CW-1:0]                 off,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic signed [SW-1:0]          sum_in,
	output logic signed [SW-1:0]          sum_out,
	input  logic signed [SAMPLE_BITS-1:0] min_in,
	output logic signed [SAMPLE_BITS-1:0] min_out,
	input  logic signed [SAMPLE_BITS-1:0] max_in,
	output logic signed [SAMPLE_BITS-1:0] max_out,
	input  logic signed [SAMPLE_BITS-1:0] x_in,
	output logic signed [SAMPLE_BITS-1:0] x_out
);

	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SW-1:0]          sum_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          in_win;

	// this cell is part of the current window
	assign in_win = (IDX <= hi);

	// sample shift line, moves on each input transfer
	always_ff @(posedge clk) begin
		if (shift_en) begin
			sample_q <= sample_in;
		end
	end

	// statistics wavefront, one cell per cycle
	always_ff @(posedge clk) begin
		sum_q <= in_win ? (sum_in + SW'(sample_q)) : sum_in;
		min_q <= (in_win && (sample_q < min_in)) ? sample_q : min_in;
		max_q <= (in_win && (sample_q > max_in)) ? sample_q : max_in;
		x_q   <= (IDX == off) ? sample_q : x_in;
	end

	assign sample_out = sample_q;
	assign sum_out    = sum_q;
	assign min_out    = min_q;
	assign max_out    = max_q;
	assign x_out      = x_q;

endmodule

`default_nettype wire

// File: src/stmsn_div.sv
// bit-serial restoring divider for the rounded Q1.15 quotient
`default_nettype none

module stmsn_div import stmsn_pkg::*; #(
	parameter int DW = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DW-1:0]        mag,
	input  logic [DW-1:0]        den,
	output logic                 busy,
	output logic [QUOT_BITS-1:0] quot
);

	localparam int RW  = DW + QUOT_BITS + 1;
	localparam int STW = $clog2(QUOT_BITS + 1);
	localparam logic [STW-1:0] LAST_STEP = STW'(QUOT_BITS - 1);

	logic [RW-1:0]        rem_q;
	logic [RW-1:0]        dsh_q;
	logic [QUOT_BITS-1:0] quot_q;
	logic [STW-1:0]       step_q;
	logic                 busy_q;
	logic                 ge;

	assign ge = (rem_q >= dsh_q);

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STW'(1);
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and quotient, one quotient bit per cycle
	// dividend is mag * 2^16 + den, divisor is 2 * den
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= RW'({mag, {QUOT_BITS{1'b0}}}) + RW'(den);
			dsh_q  <= RW'({den, {QUOT_BITS{1'b0}}});
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? (rem_q - dsh_q) : rem_q;
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QUOT_BITS-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

// File: src/short_time_mean_scale_norm_core.sv
// top level of the short-time mean and scale normalizer
`default_nettype none

// Normalizes one feature channel over a centered window of window_length
// samples (clamped to 2..MAX_WINDOW), giving (x - mean) / (max - min) in
// Q1.15. Samples sit in a row of MAX_WINDOW cells; the window sum, minimum
// and maximum are gathered by a wavefront that moves one cell per cycle.
// Each result goes through the walk, the products, the divider start, the
// serial divider (16 quotient bits and the done check) and the load of the
// output register. A flat window skips the divider. An item that gives no
// result leaves the block idle and ready for the next item. The item flagged
// stream_last produces up to half a window (rounded up) of pending results,
// each going through the same steps. The next item is taken in the cycle
// after the last result of the current one is loaded; a finished result may
// still be waiting in the output register, and a stalled output register
// holds the block in the load step. window_length must be written only while
// the block is idle; the block itself does not enforce this.
module short_time_mean_scale_norm_core import stmsn_pkg::*; #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                window_length_we,
	input  logic [CFG_BITS-1:0] window_length_wdata,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  in_item_t            sample_item,
	output logic                result_valid,
	input  logic                result_stall,
	output out_item_t           result_item
);

	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int SW = SAMPLE_BITS + CW;
	localparam int XW = SAMPLE_BITS + CW + 1;
	localparam int NW = XW + 1;
	localparam int DW = SAMPLE_BITS + CW + 1;
	localparam logic [CW-1:0] MAX_LEN = CW'(MAX_WINDOW);
	localparam logic [CFG_BITS-1:0] MAX_CFG = CFG_BITS'(MAX_WINDOW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_MUL,
		ST_NUM,
		ST_START,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [CFG_BITS-1:0] len_cfg_q;
	logic [CW-1:0]       len_w;
	logic [CW-1:0]       back_w;
	logic [CW-1:0]       front_w;
	logic [CW-1:0]       seen_q;
	logic [CW-1:0]       seen_inc;
	logic [CW-1:0]       pend_w;
	logic [CW-1:0]       back_q;
	logic [CW-1:0]       navail_q;
	logic [CW-1:0]       off_q;
	logic                last_q;
	logic [CW-1:0]       cnt_q;
	logic [CW:0]         hsum_w;
	logic [CW-1:0]       hlim_w;
	logic [CW-1:0]       hi_w;
	logic [CW-1:0]       hi_q;
	logic [CW-1:0]       n_w;
	logic signed [CW:0]  n_sx;
	logic                accept;
	logic                fin_load;
	logic                res_valid_q;
	out_item_t           res_item_q;

	// cell chain links
	logic signed [SAMPLE_BITS-1:0] smp_w [MAX_WINDOW+1];
	logic signed [SW-1:0]          sum_w [MAX_WINDOW+1];
	logic signed [SAMPLE_BITS-1:0] min_w [MAX_WINDOW+1];
	logic signed [SAMPLE_BITS-1:0] max_w [MAX_WINDOW+1];
	logic signed [SAMPLE_BITS-1:0] x_w   [MAX_WINDOW+1];

	// datapath after the walk
	logic signed [XW-1:0]          xn_s1;
	logic signed [SW-1:0]          sum_s1;
	logic [DW-1:0]                 den_s1;
	logic                          flat_s1;
	logic [SAMPLE_BITS:0]          rng_w;
	logic signed [NW-1:0]          num_w;
	logic [DW-1:0]                 mag_s2;
	logic                          neg_s2;
	logic                          div_start;
	logic                          div_busy;
	logic [QUOT_BITS-1:0]          div_quot;
	logic [NORM_BITS-1:0]          norm_w;

	// window length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q <= LEN_RESET;
		end else if (window_length_we) begin
			len_cfg_q <= window_length_wdata;
		end
	end

	// clamped length and its two halves
	always_comb begin
		if (len_cfg_q < LEN_MIN) begin
			len_w = CW'(LEN_MIN);
		end else if (len_cfg_q > MAX_CFG) begin
			len_w = MAX_LEN;
		end else begin
			len_w = CW'(len_cfg_q);
		end
		back_w  = CW'(len_w / HALF_DIV);
		front_w = len_w - back_w;
	end

	// input transfer and stream count
	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign seen_inc     = (seen_q < MAX_LEN) ? (seen_q + CW'(1)) : seen_q;
	assign pend_w       = (seen_inc < front_w) ? seen_inc : front_w;

	// last window offset, clipped to the samples held
	assign hsum_w = {1'b0, off_q} + {1'b0, back_q};
	assign hlim_w = navail_q - CW'(1);
	assign hi_w   = (hsum_w > {1'b0, hlim_w}) ? hlim_w : CW'(hsum_w);

	always_ff @(posedge clk) begin
		hi_q <= hi_w;
	end

	// row of window cells
	assign smp_w[0] = sample_item.sample;
	assign sum_w[0] = '0;
	assign min_w[0] = SMP_MAX;
	assign max_w[0] = SMP_MIN;
	assign x_w[0]   = '0;

	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		stmsn_cell #(
			.INDEX (k),
			.CW    (CW),
			.SW    (SW)
		) u_cell (
			.clk        (clk),
			.shift_en   (accept),
			.hi         (hi_q),
			.off        (off_q),
			.sample_in  (smp_w[k]),
			.sample_out (smp_w[k+1]),
			.sum_in     (sum_w[k]),
			.sum_out    (sum_w[k+1]),
			.min_in     (min_w[k]),
			.min_out    (min_w[k+1]),
			.max_in     (max_w[k]),
			.max_out    (max_w[k+1]),
			.x_in       (x_w[k]),
			.x_out      (x_w[k+1])
		);
	end

	// products: x * n and n * (max - min)
	assign n_w   = hi_q + CW'(1);
	assign n_sx  = $signed({1'b0, n_w});
	assign rng_w = $unsigned((SAMPLE_BITS+1)'(max_w[MAX_WINDOW])
		- (SAMPLE_BITS+1)'(min_w[MAX_WINDOW]));

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			xn_s1   <= XW'(x_w[MAX_WINDOW]) * XW'(n_sx);
			den_s1  <= DW'(rng_w) * DW'(n_w);
			sum_s1  <= sum_w[MAX_WINDOW];
			flat_s1 <= (max_w[MAX_WINDOW] == min_w[MAX_WINDOW]);
		end
	end

	// numerator sign and magnitude
	assign num_w = NW'(xn_s1) - NW'(sum_s1);

	always_ff @(posedge clk) begin
		if (state_q == ST_NUM) begin
			neg_s2 <= num_w[NW-1];
			mag_s2 <= num_w[NW-1] ? DW'(-num_w) : DW'(num_w);
		end
	end

	// rounded quotient
	assign div_start = (state_q == ST_START) && !flat_s1;

	stmsn_div #(
		.DW (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (mag_s2),
		.den    (den_s1),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// sign and saturation at +1
	always_comb begin
		if (flat_s1) begin
			norm_w = '0;
		end else if (neg_s2) begin
			norm_w = NORM_BITS'(~div_quot + QUOT_BITS'(1));
		end else if (div_quot > QUOT_BITS'(NORM_MAX)) begin
			norm_w = NORM_MAX;
		end else begin
			norm_w = NORM_BITS'(div_quot);
		end
	end

	assign fin_load = (state_q == ST_FIN) && (!res_valid_q || !result_stall);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seen_q      <= '0;
			back_q      <= '0;
			navail_q    <= '0;
			off_q       <= '0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			res_item_q  <= '0;
		end else begin
			// output transfer frees the register
			if (res_valid_q && !result_stall && !fin_load) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						back_q   <= back_w;
						navail_q <= seen_inc;
						cnt_q    <= '0;
						if (sample_item.stream_last) begin
							off_q   <= pend_w - CW'(1);
							last_q  <= 1'b1;
							seen_q  <= '0;
							state_q <= ST_WALK;
						end else begin
							off_q   <= front_w - CW'(1);
							last_q  <= 1'b0;
							seen_q  <= seen_inc;
							if (seen_inc >= front_w) begin
								state_q <= ST_WALK;
							end
						end
					end
				end
				ST_WALK: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == MAX_LEN) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= flat_s1 ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						res_valid_q           <= 1'b1;
						res_item_q.norm_value <= $signed(norm_w);
						res_item_q.stream_end <= last_q && (off_q == '0);
						if (last_q && (off_q != '0)) begin
							off_q   <= off_q - CW'(1);
							cnt_q   <= '0;
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result_item  = res_item_q;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// testbench for the short-time mean and scale normalizer core
`timescale 1ns / 100ps

module tb_top import stmsn_pkg::*;;

	localparam int MAX_WINDOW    = 64;
	localparam int RESULT_CYCLES = MAX_WINDOW + 22;
	localparam int SETTLE_CYCLES = RESULT_CYCLES + 15;
	localparam int RANDOM_ITEMS  = 450;
	localparam int DIR_COUNT     = 19;
	localparam longint LIMIT_NS  = 100_000_000;

	// how the samples of one random stream are drawn
	typedef enum int {FILL_FULL, FILL_NARROW, FILL_FLAT, FILL_EXTREME} fill_kind_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                window_length_we = 1'b0;
	logic [CFG_BITS-1:0] window_length_wdata = '0;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	in_item_t            sample_item = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	out_item_t           result_item;

	bit no_idle = 1'b0;

	// directed streams: a lone sample, one shorter than the front half,
	// a flat one and one built from the extreme values
	logic signed [SAMPLE_BITS-1:0] dir_vals [DIR_COUNT] = '{
		SMP_MAX,
		SMP_MIN, SMP_MAX, 16'sd0,
		-16'sd5, -16'sd5, -16'sd5, -16'sd5, -16'sd5,
		SMP_MAX, SMP_MIN, 16'sd0, -16'sd1, 16'sd1,
		SMP_MAX, SMP_MIN, SMP_MAX, 16'sd0, SMP_MIN
	};
	localparam logic [DIR_COUNT-1:0] DIR_ENDS =
		(19'd1 << 0) | (19'd1 << 3) | (19'd1 << 8) | (19'd1 << 18);

	// out-of-range and boundary window lengths come first
	logic [CFG_BITS-1:0] corner_lengths [8] = '{
		7'd2, 7'd64, 7'd0, 7'd1, 7'd127, 7'd65, 7'd3, 7'd63
	};

	// expected normalized values, worked out from the sample history
	class norm_window_tracker;
		logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
		int unsigned slot = 0;
		int unsigned seen = 0;
		int unsigned length_reg = LEN_RESET;
		out_item_t   due_norms [$];
		int unsigned mismatches = 0;

		function void set_length(logic [CFG_BITS-1:0] v);
			length_reg = v;
		endfunction

		function longint ring_at(int unsigned newest, int unsigned k);
			return longint'(ring[(newest + MAX_WINDOW - k) % MAX_WINDOW]);
		endfunction

		// value d steps older than newest, window over offsets 0..hi
		function logic [NORM_BITS-1:0] norm_of(int unsigned newest, int unsigned d,
				int unsigned hi);
			longint x, v, lo_v, hi_v, sum, n, num, den, mag, q, r;
			int unsigned k;
			x = ring_at(newest, d);
			lo_v = x;
			hi_v = x;
			sum = 0;
			for (k = 0; k <= hi; k++) begin
				v = ring_at(newest, k);
				sum += v;
				if (v < lo_v) lo_v = v;
				if (v > hi_v) hi_v = v;
			end
			if (hi_v == lo_v)
				return '0;
			n = hi + 1;
			num = x * n - sum;
			den = n * (hi_v - lo_v);
			mag = (num < 0) ? -num : num;
			// round half away from zero
			q = ((mag << (FRAC_BITS + 1)) + den) / (2 * den);
			r = (num < 0) ? -q : q;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			return r[NORM_BITS-1:0];
		endfunction

		function void push_norm(logic [NORM_BITS-1:0] v, logic fin);
			out_item_t e;
			e.norm_value = v;
			e.stream_end = fin;
			due_norms.push_back(e);
		endfunction

		// accepted sample: update the ring and queue the outputs it releases
		function void take_sample(in_item_t it);
			int unsigned len, back, front, newest, hi, d, pend;
			len = length_reg;
			if (len < LEN_MIN) len = LEN_MIN;
			if (len > MAX_WINDOW) len = MAX_WINDOW;
			back = len / HALF_DIV;
			front = len - back;
			newest = slot;
			ring[newest] = it.sample;
			slot = (newest + 1) % MAX_WINDOW;
			if (seen < MAX_WINDOW) seen++;
			if (!it.stream_last) begin
				if (seen >= front) begin
					hi = front - 1 + back;
					if (hi > seen - 1) hi = seen - 1;
					push_norm(norm_of(newest, front - 1, hi), 1'b0);
				end
				return;
			end
			// last sample flushes every pending output
			pend = (seen < front) ? seen : front;
			for (d = pend; d > 0; d--) begin
				hi = d - 1 + back;
				if (hi > seen - 1) hi = seen - 1;
				push_norm(norm_of(newest, d - 1, hi), (d == 1));
			end
			seen = 0;
			slot = 0;
		endfunction

		function void check_norm(out_item_t got);
			out_item_t want;
			if (due_norms.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: norm_value %0d stream_end %0b",
						got.norm_value, got.stream_end);
				return;
			end
			want = due_norms.pop_front();
			if (got.norm_value !== want.norm_value || got.stream_end !== want.stream_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: expected norm_value %0d stream_end %0b, %s %0d %0b",
						$realtime, want.norm_value, want.stream_end,
						"actual", got.norm_value, got.stream_end);
			end
		endfunction
	endclass

	norm_window_tracker tracker = new;

	// random stream state
	int unsigned stream_left = 0;
	int unsigned items_sent = 0;
	fill_kind_t  fill = FILL_FULL;
	logic signed [SAMPLE_BITS-1:0] fill_base = '0;

	short_time_mean_scale_norm_core #(
		.MAX_WINDOW(MAX_WINDOW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.window_length_we(window_length_we),
		.window_length_wdata(window_length_wdata),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_item(sample_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// safety limit
	initial begin
		#(LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	// result side stalls, mostly short with a few long ones
	initial begin
		int unsigned hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				result_stall = 1'b1;
				hold--;
			end else begin
				result_stall = 1'b0;
				if (!no_idle && $urandom_range(0, 99) < 20)
					hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
						: $urandom_range(10, 40);
			end
		end
	end

	// check every result transfer
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			tracker.check_norm(result_item);
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
		case (fill)
			FILL_NARROW: begin
				return fill_base + SAMPLE_BITS'(int'($urandom_range(0, 30)) - 15);
			end
			FILL_FLAT: begin
				return fill_base;
			end
			FILL_EXTREME: begin
				case ($urandom_range(0, 4))
					0: return SMP_MAX;
					1: return SMP_MIN;
					2: return 16'sd0;
					3: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
			default: begin
				return SAMPLE_BITS'($urandom);
			end
		endcase
	endfunction

	// one sample transfer; returns at the falling edge after acceptance
	task automatic send_sample(input in_item_t it);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_item = it;
		sample_valid = 1'b1;
		do
			@(posedge clk);
		while (sample_stall);
		tracker.take_sample(it);
		@(negedge clk);
	endtask

	// next sample of the running random stream, starting a new one if needed
	task automatic feed_item(input bit force_last);
		in_item_t it;
		int unsigned r;
		if (stream_left == 0) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				stream_left = $urandom_range(1, 12);
			else if (r < 85)
				stream_left = $urandom_range(13, 64);
			else
				stream_left = $urandom_range(65, 130);
			r = $urandom_range(0, 9);
			fill = (r < 5) ? FILL_FULL : (r < 7) ? FILL_NARROW
				: (r < 8) ? FILL_FLAT : FILL_EXTREME;
			fill_base = SAMPLE_BITS'($urandom);
		end
		it.sample = draw_sample();
		stream_left = force_last ? 0 : stream_left - 1;
		it.stream_last = (stream_left == 0);
		send_sample(it);
		items_sent++;
	endtask

	// drain all expected results, then let the block settle
	task automatic wait_idle();
		sample_valid = 1'b0;
		while (tracker.due_norms.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_length(input logic [CFG_BITS-1:0] v);
		window_length_we = 1'b1;
		window_length_wdata = v;
		@(posedge clk);
		tracker.set_length(v);
		@(negedge clk);
		window_length_we = 1'b0;
	endtask

	// main sequence
	initial begin
		in_item_t    it;
		int unsigned i, phase, phase_items;
		logic [CFG_BITS-1:0] len_v;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed streams at the reset window length
		for (i = 0; i < DIR_COUNT; i++) begin
			it.sample = dir_vals[i];
			it.stream_last = DIR_ENDS[i];
			send_sample(it);
		end

		// random phases; a phase may end in the middle of a stream
		phase = 0;
		while (!(items_sent >= RANDOM_ITEMS && stream_left == 0)) begin
			wait_idle();
			if (phase < 8)
				len_v = corner_lengths[phase];
			else if ($urandom_range(0, 99) < 70)
				len_v = CFG_BITS'($urandom_range(2, MAX_WINDOW));
			else
				len_v = CFG_BITS'($urandom_range(0, 127));
			write_length(len_v);
			no_idle = ($urandom_range(0, 4) == 0);
			phase_items = $urandom_range(15, 70);
			for (i = 0; i < phase_items && !(items_sent >= RANDOM_ITEMS && stream_left == 0);
					i++)
				feed_item(items_sent + 1 >= RANDOM_ITEMS);
			phase++;
		end

		wait_idle();
		if (tracker.mismatches == 0 && tracker.due_norms.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
